// File: design/tfhc_pkg.sv
// ----------------------------------------------------------------------------
// tfhc_pkg
// Types and constants shared by the tap frame header classifier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tfhc_pkg;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEAD,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        TAG_FRAME,
        TAG_BAD_MAGIC,
        TAG_BAD_LENGTH
    } tag_t;

    localparam logic [3:0] KIND_ARP        = 4'd0;
    localparam logic [3:0] KIND_ICMP_ECHO  = 4'd1;
    localparam logic [3:0] KIND_DHCP       = 4'd2;
    localparam logic [3:0] KIND_UDP        = 4'd3;
    localparam logic [3:0] KIND_TCP        = 4'd4;
    localparam logic [3:0] KIND_IGNORED    = 4'd5;
    localparam logic [3:0] KIND_ICMP_OTHER = 4'd6;
    localparam logic [3:0] KIND_IP_OTHER   = 4'd7;
    localparam logic [3:0] KIND_ETH_OTHER  = 4'd8;
    localparam logic [3:0] KIND_RUNT       = 4'd9;
    localparam logic [3:0] KIND_BAD_MAGIC  = 4'd10;
    localparam logic [3:0] KIND_BAD_LENGTH = 4'd11;
    localparam logic [3:0] KIND_BAD_TCP    = 4'd12;

    localparam logic [7:0]  MAGIC_HI       = 8'hCA;
    localparam logic [7:0]  MAGIC_LO       = 8'hFE;
    localparam logic [15:0] ETH_IPV4       = 16'h0800;
    localparam logic [15:0] ETH_ARP        = 16'h0806;
    localparam logic [15:0] ETH_IPV6       = 16'h86DD;
    localparam logic [15:0] ETH_RARP       = 16'h8035;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [15:0] ICMP_ECHO_REQ  = 16'h0800;
    localparam logic [31:0] DHCP_PORTS     = {16'd68, 16'd67};
    localparam logic [15:0] MAX_LEN_RESET  = 16'd2048;

    // one parsed frame or header error, front to back
    typedef struct packed {
        tag_t        tag;
        logic [15:0] frame_len;
        logic [47:0] dmac;
        logic [47:0] smac;
        logic [15:0] ethertype;
        logic [7:0]  proto;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [31:0] ports;
        logic [3:0]  data_offset;
    } rec_t;

endpackage

`default_nettype wire

// File: design/tap_frame_header_classifier.sv
// ----------------------------------------------------------------------------
// tap_frame_header_classifier
// Parses a tap byte stream (CA FE, 16-bit length, Ethernet frame) and emits
// one classification per frame or header error.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------------
//   in       | in_valid / in_stall   | data_byte
//   out      | out_valid / out_stall | kind, frame_length, macs, ip, ports..
//   cfg      | cfg_valid / cfg_ready | max_frame_length
//
// One byte per cycle while in_stall is low; the byte that ends a frame or a
// header pushes its result into the record queue, which feeds the output
// register. in_stall rises only while the QUEUE_DEPTH record queue is full,
// i.e. when out_stall has held results back. cfg_ready is always high. Reset
// puts the parser in header hunt, max length 2048; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tap_frame_header_classifier #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] max_frame_length,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       kind,
    output logic [15:0]      frame_length,
    output logic [47:0]      dest_mac,
    output logic [47:0]      source_mac,
    output logic [7:0]       ip_protocol,
    output logic [31:0]      source_ip,
    output logic [31:0]      dest_ip,
    output logic [15:0]      source_port,
    output logic [15:0]      dest_port,
    output logic [5:0]       tcp_header_bytes,
    output logic [15:0]      payload_length
);
    import tfhc_pkg::*;

    rec_t push_rec;
    rec_t head_rec;
    logic push;
    logic pop;
    logic full;
    logic not_empty;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;

    tfhc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (max_frame_length),
        .byte_valid (in_valid && !full),
        .byte_data  (data_byte),
        .push_rec   (push_rec),
        .push       (push)
    );

    tfhc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_rec  (head_rec)
    );

    tfhc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .not_empty        (not_empty),
        .head_rec         (head_rec),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .kind             (kind),
        .frame_length     (frame_length),
        .dest_mac         (dest_mac),
        .source_mac       (source_mac),
        .ip_protocol      (ip_protocol),
        .source_ip        (source_ip),
        .dest_ip          (dest_ip),
        .source_port      (source_port),
        .dest_port        (dest_port),
        .tcp_header_bytes (tcp_header_bytes),
        .payload_length   (payload_length)
    );

endmodule

`default_nettype wire

// File: design/tfhc_front.sv
// ----------------------------------------------------------------------------
// tfhc_front
// Header hunt, length check and field capture, one byte per cycle while byte_valid is high.
// ----------------------------------------------------------------------------
`default_nettype none

module tfhc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_valid,
    input  wire logic [15:0]   cfg_data,
    input  wire logic          byte_valid,
    input  wire logic [7:0]    byte_data,
    output tfhc_pkg::rec_t     push_rec,
    output logic               push
);
    import tfhc_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [15:0] count_reg,  count_next;
    logic [15:0] len_reg,    len_next;
    logic        magic_reg,  magic_next;
    logic [15:0] maxlen_reg;
    logic [47:0] dmac_reg,   dmac_next;
    logic [47:0] smac_reg,   smac_next;
    logic [15:0] et_reg,     et_next;
    logic [7:0]  proto_reg,  proto_next;
    logic [31:0] sip_reg,    sip_next;
    logic [31:0] dip_reg,    dip_next;
    logic [31:0] ports_reg,  ports_next;
    logic [3:0]  doff_reg,   doff_next;
    logic [15:0] len_full;
    logic [16:0] count_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxlen_reg <= MAX_LEN_RESET;
        end
        else if (cfg_valid)
        begin
            maxlen_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
            len_reg   <= '0;
            magic_reg <= 1'b0;
            dmac_reg  <= '0;
            smac_reg  <= '0;
            et_reg    <= '0;
            proto_reg <= '0;
            sip_reg   <= '0;
            dip_reg   <= '0;
            ports_reg <= '0;
            doff_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            magic_reg <= magic_next;
            dmac_reg  <= dmac_next;
            smac_reg  <= smac_next;
            et_reg    <= et_next;
            proto_reg <= proto_next;
            sip_reg   <= sip_next;
            dip_reg   <= dip_next;
            ports_reg <= ports_next;
            doff_reg  <= doff_next;
        end
    end

    assign len_full  = {len_reg[15:8], byte_data};
    assign count_inc = {1'b0, count_reg} + 17'd1;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        len_next   = len_reg;
        magic_next = magic_reg;
        dmac_next  = dmac_reg;
        smac_next  = smac_reg;
        et_next    = et_reg;
        proto_next = proto_reg;
        sip_next   = sip_reg;
        dip_next   = dip_reg;
        ports_next = ports_reg;
        doff_next  = doff_reg;
        push       = 1'b0;
        push_rec.tag = TAG_FRAME;

        if (byte_valid)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (byte_data == MAGIC_HI)
                    begin
                        phase_next = PH_HEAD;
                        count_next = 16'd1;
                        magic_next = 1'b1;
                        len_next   = '0;
                    end
                end
                PH_HEAD:
                begin
                    priority if (count_reg == 16'd1)
                    begin
                        magic_next = magic_reg && (byte_data == MAGIC_LO);
                        count_next = 16'd2;
                    end
                    else if (count_reg == 16'd2)
                    begin
                        len_next   = {byte_data, 8'h00};
                        count_next = 16'd3;
                    end
                    else
                    begin
                        len_next   = len_full;
                        count_next = '0;
                        priority if (!magic_reg)
                        begin
                            phase_next   = PH_HUNT;
                            push         = 1'b1;
                            push_rec.tag = TAG_BAD_MAGIC;
                        end
                        else if (len_full == 16'd0 || len_full > maxlen_reg)
                        begin
                            phase_next   = PH_HUNT;
                            push         = 1'b1;
                            push_rec.tag = TAG_BAD_LENGTH;
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                            dmac_next  = '0;
                            smac_next  = '0;
                            et_next    = '0;
                            proto_next = '0;
                            sip_next   = '0;
                            dip_next   = '0;
                            ports_next = '0;
                            doff_next  = '0;
                        end
                    end
                end
                PH_BODY:
                begin
                    priority if (count_reg < 16'd6)
                        dmac_next = {dmac_reg[39:0], byte_data};
                    else if (count_reg < 16'd12)
                        smac_next = {smac_reg[39:0], byte_data};
                    else if (count_reg < 16'd14)
                        et_next = {et_reg[7:0], byte_data};
                    else if (count_reg == 16'd23)
                        proto_next = byte_data;
                    else if (count_reg >= 16'd26 && count_reg < 16'd30)
                        sip_next = {sip_reg[23:0], byte_data};
                    else if (count_reg >= 16'd30 && count_reg < 16'd34)
                        dip_next = {dip_reg[23:0], byte_data};
                    else if (count_reg >= 16'd34 && count_reg < 16'd38)
                        ports_next = {ports_reg[23:0], byte_data};
                    else if (count_reg == 16'd46)
                        doff_next = byte_data[7:4];
                    else
                    begin
                    end

                    if (count_inc >= {1'b0, len_reg})
                    begin
                        push       = 1'b1;
                        phase_next = PH_HUNT;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_inc[15:0];
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        push_rec.frame_len   = len_next;
        push_rec.dmac        = dmac_next;
        push_rec.smac        = smac_next;
        push_rec.ethertype   = et_next;
        push_rec.proto       = proto_next;
        push_rec.sip         = sip_next;
        push_rec.dip         = dip_next;
        push_rec.ports       = ports_next;
        push_rec.data_offset = doff_next;
    end

endmodule

`default_nettype wire

// File: design/tfhc_queue.sv
// ----------------------------------------------------------------------------
// tfhc_queue
// Short record queue between the parser and the classifier.
// ----------------------------------------------------------------------------
`default_nettype none

module tfhc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire tfhc_pkg::rec_t push_rec,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output tfhc_pkg::rec_t      head_rec
);
    import tfhc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    rec_t          store [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign full      = (count_reg == FULL_COUNT);
    assign not_empty = (count_reg != '0);
    assign head_rec  = store[rd_ptr_reg];

endmodule

`default_nettype wire

// File: design/tfhc_back.sv
// ----------------------------------------------------------------------------
// tfhc_back
// Classifies one queued record per cycle into the output register, unless out_stall holds a result there.
// ----------------------------------------------------------------------------
`default_nettype none

module tfhc_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           not_empty,
    input  wire tfhc_pkg::rec_t head_rec,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [3:0]          kind,
    output logic [15:0]         frame_length,
    output logic [47:0]         dest_mac,
    output logic [47:0]         source_mac,
    output logic [7:0]          ip_protocol,
    output logic [31:0]         source_ip,
    output logic [31:0]         dest_ip,
    output logic [15:0]         source_port,
    output logic [15:0]         dest_port,
    output logic [5:0]          tcp_header_bytes,
    output logic [15:0]         payload_length
);
    import tfhc_pkg::*;

    logic        valid_reg;
    logic [3:0]  kind_reg,  kind_next;
    logic [15:0] len_reg;
    logic [47:0] dmac_reg,  dmac_next;
    logic [47:0] smac_reg,  smac_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] sip_reg,   sip_next;
    logic [31:0] dip_reg,   dip_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] dport_reg, dport_next;
    logic [5:0]  tcpb_reg,  tcpb_next;
    logic [15:0] pay_reg,   pay_next;

    logic [15:0] len;
    logic [5:0]  hdr;
    logic        ipflow;
    logic        is_frame;

    assign pop = not_empty && (!valid_reg || !out_stall);

    always_comb
    begin
        len      = head_rec.frame_len;
        hdr      = {head_rec.data_offset, 2'b00};
        is_frame = (head_rec.tag == TAG_FRAME);
        ipflow   = 1'b0;
        tcpb_next = '0;
        pay_next  = '0;
        kind_next = KIND_ETH_OTHER;

        unique case (head_rec.tag)
            TAG_BAD_MAGIC:  kind_next = KIND_BAD_MAGIC;
            TAG_BAD_LENGTH: kind_next = KIND_BAD_LENGTH;
            TAG_FRAME:
            begin
                priority if (len <= 16'd14)
                    kind_next = KIND_RUNT;
                else if (head_rec.ethertype == ETH_ARP)
                    kind_next = (len < 16'd42) ? KIND_RUNT : KIND_ARP;
                else if (head_rec.ethertype == ETH_IPV4)
                begin
                    priority if (len <= 16'd34)
                        kind_next = KIND_RUNT;
                    else if (head_rec.proto == PROTO_ICMP)
                    begin
                        priority if (len <= 16'd42)
                            kind_next = KIND_RUNT;
                        else if (head_rec.ports[31:16] == ICMP_ECHO_REQ)
                            kind_next = KIND_ICMP_ECHO;
                        else
                            kind_next = KIND_ICMP_OTHER;
                    end
                    else if (head_rec.proto == PROTO_UDP)
                    begin
                        if (len <= 16'd42)
                        begin
                            kind_next = KIND_RUNT;
                        end
                        else
                        begin
                            kind_next = (head_rec.ports == DHCP_PORTS) ? KIND_DHCP
                                                                       : KIND_UDP;
                            ipflow    = 1'b1;
                            pay_next  = len - 16'd42;
                        end
                    end
                    else if (head_rec.proto == PROTO_TCP)
                    begin
                        if (len < 16'd54)
                        begin
                            kind_next = KIND_RUNT;
                        end
                        else
                        begin
                            tcpb_next = hdr;
                            if (hdr < 6'd20 || {1'b0, len} < 17'd34 + {11'b0, hdr})
                            begin
                                kind_next = KIND_BAD_TCP;
                            end
                            else
                            begin
                                kind_next = KIND_TCP;
                                ipflow    = 1'b1;
                                pay_next  = len - 16'd34 - {10'b0, hdr};
                            end
                        end
                    end
                    else
                        kind_next = KIND_IP_OTHER;
                end
                else if (head_rec.ethertype == ETH_IPV6 || head_rec.ethertype == ETH_RARP)
                    kind_next = KIND_IGNORED;
                else
                    kind_next = KIND_ETH_OTHER;
            end
            default: kind_next = KIND_BAD_MAGIC;
        endcase

        dmac_next  = is_frame ? head_rec.dmac : '0;
        smac_next  = is_frame ? head_rec.smac : '0;
        proto_next = (is_frame && head_rec.ethertype == ETH_IPV4) ? head_rec.proto : '0;
        sip_next   = ipflow ? head_rec.sip : '0;
        dip_next   = ipflow ? head_rec.dip : '0;
        sport_next = ipflow ? head_rec.ports[31:16] : '0;
        dport_next = ipflow ? head_rec.ports[15:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg  <= kind_next;
            len_reg   <= head_rec.frame_len;
            dmac_reg  <= dmac_next;
            smac_reg  <= smac_next;
            proto_reg <= proto_next;
            sip_reg   <= sip_next;
            dip_reg   <= dip_next;
            sport_reg <= sport_next;
            dport_reg <= dport_next;
            tcpb_reg  <= tcpb_next;
            pay_reg   <= pay_next;
        end
    end

    assign out_valid        = valid_reg;
    assign kind             = kind_reg;
    assign frame_length     = len_reg;
    assign dest_mac         = dmac_reg;
    assign source_mac       = smac_reg;
    assign ip_protocol      = proto_reg;
    assign source_ip        = sip_reg;
    assign dest_ip          = dip_reg;
    assign source_port      = sport_reg;
    assign dest_port        = dport_reg;
    assign tcp_header_bytes = tcpb_reg;
    assign payload_length   = pay_reg;

endmodule

`default_nettype wire

// File: design/tfhc_checker.sv
// ----------------------------------------------------------------------------
// tfhc_checker
// Port-level checks on the classifier's result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module tfhc_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [3:0]  kind,
    input  wire logic [15:0] frame_length,
    input  wire logic [47:0] dest_mac,
    input  wire logic [47:0] source_mac,
    input  wire logic [5:0]  tcp_header_bytes,
    input  wire logic [15:0] payload_length
);
    import tfhc_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(frame_length))
        else $error("result changed while stalled");

    a_hdr_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_BAD_MAGIC || kind == KIND_BAD_LENGTH)
        |-> dest_mac == '0 && source_mac == '0 && payload_length == '0)
        else $error("header error carries frame fields");

    a_tcpb: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_TCP && kind != KIND_BAD_TCP |-> tcp_header_bytes == '0)
        else $error("tcp header bytes on non-tcp result");

    a_tcp_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_TCP
        |-> tcp_header_bytes >= 6'd20 &&
            {1'b0, payload_length} + 17'd34 + {11'b0, tcp_header_bytes}
            == {1'b0, frame_length})
        else $error("tcp payload length mismatch");

    a_udp_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_UDP || kind == KIND_DHCP)
        |-> {1'b0, payload_length} + 17'd42 == {1'b0, frame_length})
        else $error("udp payload length mismatch");

endmodule

bind tap_frame_header_classifier tfhc_checker u_tfhc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .kind             (kind),
    .frame_length     (frame_length),
    .dest_mac         (dest_mac),
    .source_mac       (source_mac),
    .tcp_header_bytes (tcp_header_bytes),
    .payload_length   (payload_length)
);

`default_nettype wire
